// ----- rtl/slt_pkg.sv -----
// Package for the Sauvola local threshold block: sizes, command codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package slt_pkg;
	localparam int MaxWidth = 256;
	localparam int MaxHeight = 256;
	localparam int MaxRadius = 7;
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight);
	localparam int AddrW = ColW + RowW;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic load;
		logic clr_minmax;
		logic wr_pix;
		logic scan_init;
		logic scan_step;
		logic div_start;
		logic sqrt_start;
		logic thr_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_image;
		logic flat;
		logic scan_last;
		logic div_done;
		logic sqrt_done;
		logic thr_done;
	} sts_t;
endpackage

// ----- rtl/sauvola_local_threshold.sv -----
// Top level of the Sauvola local threshold block: registers, controller, datapath.
// Depends on slt_pkg, slt_ctrl and slt_datapath.
//   channel | signals                                     | transfer
//   command | start busy kind row col pixel               | start && !busy
//   result  | strobe level threshold_q8_8 out_of_range    | strobe, one cycle
//   config  | cfg_valid cfg_ready cfg_index cfg_data      | cfg_valid && cfg_ready
// A start, write or unused kind keeps busy high through the decode state only; an
// out-of-range or flat query through decode, wait and output. A query in the image
// keeps busy high while the window pixels are read one per cycle (at most 225), then
// while serial divides for the mean, variance and threshold and a square root run.
// The strobe rises as busy falls. Reset clears control state; the
// frame is undefined. The receiver cannot stall; the strobe lasts one cycle.
`timescale 1ns / 1ps
module sauvola_local_threshold (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  row,
	input  logic [7:0]  col,
	input  logic [7:0]  pixel,
	output logic        strobe,
	output logic [7:0]  level,
	output logic [15:0] threshold_q8_8,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	logic [8:0] w_q, h_q;
	logic [2:0] r_q;
	slt_pkg::cmd_t cmd;
	slt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 9'd256;
			h_q <= 9'd256;
			r_q <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slt_pkg::REG_WIDTH: w_q <= (cfg_data == 9'd0) ? 9'd1 :
					(cfg_data > 9'(slt_pkg::MaxWidth)) ? 9'(slt_pkg::MaxWidth) : cfg_data;
				slt_pkg::REG_HEIGHT: h_q <= (cfg_data == 9'd0) ? 9'd1 :
					(cfg_data > 9'(slt_pkg::MaxHeight)) ? 9'(slt_pkg::MaxHeight) : cfg_data;
				slt_pkg::REG_RADIUS: r_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	slt_ctrl u_ctrl (.clk, .arst_n, .start, .kind, .busy, .strobe, .cmd, .sts);

	slt_datapath u_dp (.clk, .arst_n, .cmd, .sts, .row, .col, .pixel,
		.img_w(w_q), .img_h(h_q), .rad(r_q), .level, .threshold_q8_8, .out_of_range);
endmodule

// ----- rtl/slt_datapath.sv -----
// Datapath: frame memory, min/max tracking, window scan, serial divider and square root.
// Depends on slt_pkg.
`timescale 1ns / 1ps
module slt_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slt_pkg::cmd_t        cmd,
	output slt_pkg::sts_t        sts,
	input  logic [7:0]           row,
	input  logic [7:0]           col,
	input  logic [7:0]           pixel,
	input  logic [8:0]           img_w,
	input  logic [8:0]           img_h,
	input  logic [2:0]           rad,
	output logic [7:0]           level,
	output logic [15:0]          threshold_q8_8,
	output logic                 out_of_range
);
	localparam logic [1:0] PH_MEAN = 2'd0, PH_VAR = 2'd1, PH_THR = 2'd2;

	logic [7:0] mem [0:(1 << slt_pkg::AddrW) - 1];
	logic [7:0] row_q, col_q, pix_q, rd_s1, min_q, max_q, center_q;
	logic [8:0] r_lo_q, r_hi_q, c_lo_q, c_hi_q, y_q, x_q;
	logic       rd_vld_s1, center_s1;
	logic [8:0] cnt_q;
	logic [16:0] sum_q;
	logic [24:0] sumsq_q;
	// Shared restoring divider: quotient of num_q by den_q, one bit per cycle.
	logic [47:0] num_q, quo_q;
	logic [47:0] rem_q;
	logic [36:0] den_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q;
	logic [1:0]  phase_q;
	logic [47:0] div_sh;
	logic        div_ge;
	logic [16:0] mean_q;
	logic [33:0] spread_q;
	logic [29:0] var_q;
	logic [31:0] sqv_q, res_q, sbit_q;
	logic        sbusy_q;
	logic [15:0] sd_q;
	logic        in_img;
	logic [8:0]  rowe, cole, ye, xe;

	assign rowe = {1'b0, row_q};
	assign cole = {1'b0, col_q};
	assign in_img = (rowe < img_h) && (cole < img_w);
	assign sts.in_image = in_img;
	assign sts.flat = (max_q <= min_q);
	assign sts.scan_last = (y_q == r_hi_q) && (x_q == c_hi_q);
	assign sts.div_done = !dbusy_q && !cmd.div_start;
	assign sts.sqrt_done = !sbusy_q && !cmd.sqrt_start;
	assign sts.thr_done = !dbusy_q && !cmd.thr_start;
	assign ye = y_q;
	assign xe = x_q;
	assign div_sh = {rem_q[46:0], num_q[47]};
	assign div_ge = (div_sh >= {11'd0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= row;
			col_q <= col;
			pix_q <= pixel;
		end
		if (cmd.wr_pix)
			mem[{row_q[slt_pkg::RowW-1:0], col_q[slt_pkg::ColW-1:0]}] <= pix_q;
		rd_s1 <= mem[{ye[slt_pkg::RowW-1:0], xe[slt_pkg::ColW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 8'd255;
			max_q <= 8'd0;
		end else if (cmd.clr_minmax) begin
			min_q <= 8'd255;
			max_q <= 8'd0;
		end else if (cmd.wr_pix) begin
			if (pix_q < min_q) min_q <= pix_q;
			if (pix_q > max_q) max_q <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			center_s1 <= 1'b0;
			dbusy_q <= 1'b0;
			sbusy_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			center_s1 <= cmd.scan_step && (y_q == rowe) && (x_q == cole);
			if (cmd.div_start || cmd.thr_start) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == 6'd0 && phase_q != PH_MEAN) dbusy_q <= 1'b0;
			if (cmd.sqrt_start) sbusy_q <= 1'b1;
			else if (sbusy_q && sbit_q == 32'd0) sbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			r_lo_q <= (rowe > {6'd0, rad}) ? rowe - {6'd0, rad} : 9'd0;
			r_hi_q <= (rowe + {6'd0, rad} < img_h) ? rowe + {6'd0, rad} : img_h - 9'd1;
			c_lo_q <= (cole > {6'd0, rad}) ? cole - {6'd0, rad} : 9'd0;
			c_hi_q <= (cole + {6'd0, rad} < img_w) ? cole + {6'd0, rad} : img_w - 9'd1;
			y_q <= (rowe > {6'd0, rad}) ? rowe - {6'd0, rad} : 9'd0;
			x_q <= (cole > {6'd0, rad}) ? cole - {6'd0, rad} : 9'd0;
			cnt_q <= 9'd0;
			sum_q <= '0;
			sumsq_q <= '0;
		end else if (cmd.scan_step) begin
			if (x_q == c_hi_q) begin
				x_q <= c_lo_q;
				y_q <= y_q + 9'd1;
			end else begin
				x_q <= x_q + 9'd1;
			end
		end
		if (rd_vld_s1) begin
			cnt_q <= cnt_q + 9'd1;
			sum_q <= sum_q + {9'd0, rd_s1};
			sumsq_q <= sumsq_q + {9'd0, {8'd0, rd_s1} * {8'd0, rd_s1}};
		end
		if (center_s1) center_q <= rd_s1;
	end

	// Divider phases: mean, then variance, later the threshold.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			spread_q <= 34'({16'd0, cnt_q} * {9'd0, sumsq_q}) - 34'(sum_q * sum_q);
			num_q <= {23'd0, sum_q, 8'd0} + {39'd0, cnt_q >> 1};
			den_q <= {28'd0, cnt_q};
			rem_q <= '0;
			dcnt_q <= 6'd47;
			phase_q <= PH_MEAN;
		end else if (cmd.thr_start) begin
			num_q <= 48'(mean_q * ({8'd0, max_q - min_q, 10'd0} + {9'd0, sd_q, 1'b0}))
				+ 48'(640 * {29'd0, max_q - min_q});
			den_q <= 37'(1280 * {29'd0, max_q - min_q});
			rem_q <= '0;
			dcnt_q <= 6'd47;
			phase_q <= PH_THR;
		end else if (dbusy_q && dcnt_q == 6'd0 && phase_q == PH_MEAN) begin
			mean_q <= {quo_q[15:0], div_ge};
			num_q <= {spread_q, 14'd0} << 2;
			den_q <= 37'({28'd0, cnt_q} * {28'd0, cnt_q});
			rem_q <= '0;
			dcnt_q <= 6'd47;
			phase_q <= PH_VAR;
		end else if (dbusy_q) begin
			if (div_ge) begin
				rem_q <= div_sh - {11'd0, den_q};
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= div_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
			num_q <= {num_q[46:0], 1'b0};
			dcnt_q <= dcnt_q - 6'd1;
			if (dcnt_q == 6'd0 && phase_q == PH_VAR)
				var_q <= {quo_q[28:0], div_ge};
		end
	end

	// Bit-pair square root of the Q16 variance.
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sqv_q <= {2'd0, var_q};
			res_q <= '0;
			sbit_q <= 32'h1000_0000;
		end else if (sbusy_q) begin
			if (sqv_q >= res_q + sbit_q) begin
				sqv_q <= sqv_q - res_q - sbit_q;
				res_q <= (res_q >> 1) + sbit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
			if (sbit_q == 32'd1) sd_q <= 16'((sqv_q >= res_q + sbit_q) ? (res_q >> 1) + 32'd1
				: res_q >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (!in_img) begin
				level <= 8'd0;
				threshold_q8_8 <= 16'd0;
				out_of_range <= 1'b1;
			end else if (max_q <= min_q) begin
				level <= 8'd255;
				threshold_q8_8 <= 16'd0;
				out_of_range <= 1'b0;
			end else begin
				threshold_q8_8 <= (quo_q[47:16] != 32'd0) ? 16'hFFFF : quo_q[15:0];
				level <= ({center_q, 8'd0} < ((quo_q[47:16] != 32'd0) ? 16'hFFFF : quo_q[15:0]))
					? 8'd0 : 8'd255;
				out_of_range <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_pix |=> (min_q <= pix_q) && (max_q >= pix_q)) else $error("minmax");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_minmax |=> (min_q == 8'd255) && (max_q == 8'd0)) else $error("clear");
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (y_q <= r_hi_q)) else $error("scan bound");
`endif
endmodule

// ----- rtl/slt_ctrl.sv -----
// Controller state machine sequencing writes, the window scan and the arithmetic.
// Depends on slt_pkg.
`timescale 1ns / 1ps
module slt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    kind,
	output logic          busy,
	output logic          strobe,
	output slt_pkg::cmd_t cmd,
	input  slt_pkg::sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2, S_DRAIN = 4'd3,
		S_DIV = 4'd4, S_SQRT = 4'd5, S_THR = 4'd6, S_OUT = 4'd7, S_WAIT = 4'd8,
		S_DIVW = 4'd9, S_SQW = 4'd10, S_THW = 4'd11;
	logic [3:0] state_q, nxt;
	logic [1:0] kind_q;
	logic [1:0] dly_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		nxt = state_q;
		cmd.load = (state_q == S_IDLE) && start;
		unique case (state_q)
			S_IDLE: if (start) nxt = S_DEC;
			S_DEC: begin
				if (kind_q == slt_pkg::KIND_START) begin
					cmd.clr_minmax = 1'b1;
					nxt = S_IDLE;
				end else if (kind_q == slt_pkg::KIND_WRITE) begin
					cmd.wr_pix = sts.in_image;
					nxt = S_IDLE;
				end else if (kind_q == slt_pkg::KIND_QUERY) begin
					cmd.scan_init = 1'b1;
					nxt = (sts.in_image && !sts.flat) ? S_SCAN : S_WAIT;
				end else begin
					nxt = S_IDLE;
				end
			end
			S_WAIT: nxt = S_OUT;
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) nxt = S_DRAIN;
			end
			S_DRAIN: if (dly_q == 2'd2) nxt = S_DIV;
			S_DIV: begin
				cmd.div_start = 1'b1;
				nxt = S_DIVW;
			end
			S_DIVW: if (sts.div_done && dly_q == 2'd3) nxt = S_SQRT;
			S_SQRT: begin
				cmd.sqrt_start = 1'b1;
				nxt = S_SQW;
			end
			S_SQW: if (sts.sqrt_done) nxt = S_THR;
			S_THR: begin
				cmd.thr_start = 1'b1;
				nxt = S_THW;
			end
			S_THW: if (sts.thr_done && dly_q == 2'd3) nxt = S_OUT;
			S_OUT: begin
				cmd.finish = 1'b1;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= slt_pkg::KIND_START;
			dly_q <= 2'd0;
			strobe <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.load) kind_q <= kind;
			strobe <= cmd.finish;
			if (nxt != state_q) dly_q <= 2'd0;
			else if (dly_q != 2'd3) dly_q <= dly_q + 2'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_OUT)) else $error("strobe");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy");
	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_start, cmd.sqrt_start, cmd.thr_start})) else $error("cmd");
`endif
endmodule
